// ===== hw/rtl/acs_pkg.sv =====
// shared types and constants of the anticogging calibration sequencer
package acs_pkg;

    // field widths
    localparam int POS_W      = 16;
    localparam int CUR_W      = 32;
    localparam int VAL_W      = 16;
    localparam int IDX_W      = 12;
    localparam int ACT_W      = 2;
    localparam int PRE_W      = 16;
    localparam int SET_W      = 10;
    localparam int GAIN_W     = 16;
    localparam int STEP_W     = 14;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // action codes
    localparam logic [ACT_W-1:0] ACT_TICK  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_START = 2'd1;
    localparam logic [ACT_W-1:0] ACT_END   = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PRESCALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 2'd2;

    // register reset values
    localparam logic [PRE_W-1:0]  PRESCALE_RST = 16'd500;
    localparam logic [SET_W-1:0]  SETTLE_RST   = 10'd100;
    localparam logic [GAIN_W-1:0] GAIN_RST     = 16'd5000;

    localparam logic [STEP_W-1:0] STEP_MAX = 14'h3FFF;

    // commands from the controller to the datapath
    typedef struct packed {
        logic clr_en;
        logic load_in;
        logic clr_ctrs;
        logic tick_upd;
        logic phase_latch;
        logic exec;
        logic out_load;
    } acs_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic             tick_hit;
        logic             table_valid;
        logic             clr_last;
        logic             out_free;
    } acs_sts_t;

endpackage

// ===== hw/rtl/acs_if.sv =====
// request, result and configuration channel interfaces
interface acs_req_if;
    logic                               valid;
    logic                               ready;
    logic [acs_pkg::ACT_W-1:0]          action;
    logic                               motor_id;
    logic [acs_pkg::POS_W-1:0]          position;
    logic signed [acs_pkg::CUR_W-1:0]   current_q;

    modport source (output valid, action, motor_id, position, current_q, input ready);
    modport sink   (input valid, action, motor_id, position, current_q, output ready);
endinterface

interface acs_rsp_if;
    logic                               valid;
    logic                               ready;
    logic                               motor_out;
    logic [acs_pkg::POS_W-1:0]          new_position;
    logic                               table_write;
    logic [acs_pkg::IDX_W-1:0]          table_index;
    logic signed [acs_pkg::VAL_W-1:0]   table_value;
    logic                               done_res;
    logic                               disarm;

    modport source (output valid, motor_out, new_position, table_write, table_index,
                    table_value, done_res, disarm, input ready);
    modport sink   (input valid, motor_out, new_position, table_write, table_index,
                    table_value, done_res, disarm, output ready);
endinterface

interface acs_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [acs_pkg::CFG_IDX_W-1:0]      index;
    logic [acs_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/acs_ctrl.sv =====
// controller state machine of the calibration sequencer
module acs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  acs_pkg::acs_sts_t sts,
    output acs_pkg::acs_cmd_t cmd
);

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_DECODE = 3'd2;
    localparam logic [2:0] S_CLEAR  = 3'd3;
    localparam logic [2:0] S_TICK   = 3'd4;
    localparam logic [2:0] S_PHASE  = 3'd5;
    localparam logic [2:0] S_WRITE  = 3'd6;
    localparam logic [2:0] S_OUT    = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.clr_en = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (sts.action)
                    acs_pkg::ACT_START:
                    begin
                        cmd.clr_ctrs = 1'b1;
                        state_next   = S_CLEAR;
                    end
                    acs_pkg::ACT_END:
                    begin
                        state_next = sts.table_valid ? S_OUT : S_CLEAR;
                    end
                    acs_pkg::ACT_TICK:
                    begin
                        state_next = S_TICK;
                    end
                    default:
                    begin
                        state_next = S_OUT;
                    end
                endcase
            end
            S_CLEAR:
            begin
                cmd.clr_en = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_OUT;
                end
            end
            S_TICK:
            begin
                cmd.tick_upd = 1'b1;
                state_next   = sts.tick_hit ? S_PHASE : S_OUT;
            end
            S_PHASE:
            begin
                cmd.phase_latch = 1'b1;
                state_next      = S_WRITE;
            end
            S_WRITE:
            begin
                cmd.exec   = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/acs_dp.sv =====
// datapath of the calibration sequencer: counters, scaling, table memory, result register
module acs_dp #(
    parameter int MAP_ENTRIES = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  acs_pkg::acs_cmd_t                   cmd,
    output acs_pkg::acs_sts_t                   sts,
    input  logic                                cfg_we,
    input  logic [acs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [acs_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic [acs_pkg::ACT_W-1:0]           req_action,
    input  logic                                req_motor_id,
    input  logic [acs_pkg::POS_W-1:0]           req_position,
    input  logic signed [acs_pkg::CUR_W-1:0]    req_current_q,
    input  logic                                rsp_ready,
    output logic                                rsp_valid,
    output logic                                rsp_motor_out,
    output logic [acs_pkg::POS_W-1:0]           rsp_new_position,
    output logic                                rsp_table_write,
    output logic [acs_pkg::IDX_W-1:0]           rsp_table_index,
    output logic signed [acs_pkg::VAL_W-1:0]    rsp_table_value,
    output logic                                rsp_done_res,
    output logic                                rsp_disarm
);

    localparam int AW = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
    localparam int PW = 17 + AW;
    localparam logic [15:0]   PosDelta = 16'(65536 / MAP_ENTRIES);
    localparam logic [14:0]   MapCount = 15'(MAP_ENTRIES);
    localparam logic [AW:0]   MapEnt   = (AW + 1)'(MAP_ENTRIES);
    localparam logic [AW-1:0] LastAddr = AW'(MAP_ENTRIES - 1);

    localparam logic [2:0] PH_SET_CW  = 3'd0;
    localparam logic [2:0] PH_REC_CW  = 3'd1;
    localparam logic [2:0] PH_SET_CCW = 3'd2;
    localparam logic [2:0] PH_AVG_CCW = 3'd3;
    localparam logic [2:0] PH_DONE    = 3'd4;

    // configuration
    logic [15:0] prescale_reg;
    logic [9:0]  settle_reg;
    logic [15:0] gain_reg;

    // captured request
    logic [1:0]         action_reg;
    logic [15:0]        pos_reg;
    logic signed [31:0] cur_reg;

    // sequencing state
    logic [15:0] tick_reg;
    logic [13:0] step_reg;
    logic        valid_reg;
    logic [AW-1:0] clr_addr_reg;

    // working registers
    logic signed [48:0] prod_reg;
    logic [AW-1:0]      idx_reg;
    logic [2:0]         phase_reg;
    logic signed [15:0] scaled_reg;
    logic signed [15:0] rdata_reg;

    // staged result
    logic               res_motor_reg;
    logic [15:0]        res_newpos_reg;
    logic               res_wr_reg;
    logic [AW-1:0]      res_idx_reg;
    logic signed [15:0] res_val_reg;
    logic               res_done_reg;
    logic               res_disarm_reg;

    // output register
    logic               out_valid_reg;
    logic               out_motor_reg;
    logic [15:0]        out_newpos_reg;
    logic               out_wr_reg;
    logic [AW-1:0]      out_idx_reg;
    logic signed [15:0] out_val_reg;
    logic               out_done_reg;
    logic               out_disarm_reg;

    logic signed [15:0] cog_mem [0:MAP_ENTRIES-1];

    logic [16:0]        tick_inc;
    logic               tick_hit;
    logic [PW-1:0]      pos_prod;
    logic [AW:0]        pos_q;
    logic [15:0]        pos_r;
    logic               round_up;
    logic [AW:0]        pos_qr;
    logic [AW-1:0]      idx_calc;
    logic signed [48:0] prod_calc;
    logic signed [32:0] sc_q;
    logic signed [32:0] sc_adj;
    logic signed [15:0] scaled_calc;
    logic signed [16:0] avg_sum;
    logic signed [16:0] avg_adj;
    logic signed [15:0] avg_val;
    logic [14:0]        s_ext;
    logic [14:0]        b1;
    logic [14:0]        b2;
    logic [14:0]        b3;
    logic [14:0]        b4;
    logic [2:0]         phase_calc;
    logic               mem_we;
    logic [AW-1:0]      mem_addr;
    logic signed [15:0] mem_wdata;
    logic               clr_last;

    // tick prescaler
    assign tick_inc = {1'b0, tick_reg} + 17'd1;
    assign tick_hit = (tick_inc >= {1'b0, prescale_reg});

    // position to table index, rounded half to even
    assign pos_prod = PW'(pos_reg) * PW'(MAP_ENTRIES);
    assign pos_q    = pos_prod[PW-1:16];
    assign pos_r    = pos_prod[15:0];
    assign round_up = (pos_r > 16'h8000) || ((pos_r == 16'h8000) && pos_q[0]);
    assign pos_qr   = pos_q + {{AW{1'b0}}, round_up};
    assign idx_calc = (pos_qr >= MapEnt) ? '0 : pos_qr[AW-1:0];

    // current scaling, truncated toward zero and saturated
    assign prod_calc = cur_reg * $signed({1'b0, gain_reg});
    assign sc_q      = prod_reg[48:16];
    assign sc_adj    = sc_q + $signed({32'd0, (prod_reg[48] && (prod_reg[15:0] != 16'd0))});

    always_comb
    begin
        if (sc_adj > 33'sd32767)
        begin
            scaled_calc = 16'sh7FFF;
        end
        else if (sc_adj < -33'sd32768)
        begin
            scaled_calc = 16'sh8000;
        end
        else
        begin
            scaled_calc = sc_adj[15:0];
        end
    end

    // mean of stored and new value, truncated toward zero
    assign avg_sum = rdata_reg + scaled_reg;
    assign avg_adj = avg_sum + $signed({16'd0, (avg_sum[16] & avg_sum[0])});
    assign avg_val = avg_adj[16:1];

    // phase boundaries follow the live registers
    assign s_ext = {1'b0, step_reg};
    assign b1    = {5'd0, settle_reg};
    assign b2    = b1 + MapCount;
    assign b3    = b2 + b1;
    assign b4    = b3 + MapCount;

    always_comb
    begin
        if (s_ext <= b1)
        begin
            phase_calc = PH_SET_CW;
        end
        else if (s_ext <= b2)
        begin
            phase_calc = PH_REC_CW;
        end
        else if (s_ext <= b3)
        begin
            phase_calc = PH_SET_CCW;
        end
        else if (s_ext <= b4)
        begin
            phase_calc = PH_AVG_CCW;
        end
        else
        begin
            phase_calc = PH_DONE;
        end
    end

    assign clr_last = (clr_addr_reg == LastAddr);

    assign sts.action      = action_reg;
    assign sts.tick_hit    = tick_hit;
    assign sts.table_valid = valid_reg;
    assign sts.clr_last    = clr_last;
    assign sts.out_free    = !out_valid_reg || rsp_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_reg <= acs_pkg::PRESCALE_RST;
            settle_reg   <= acs_pkg::SETTLE_RST;
            gain_reg     <= acs_pkg::GAIN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                acs_pkg::CFG_PRESCALE: prescale_reg <= cfg_data;
                acs_pkg::CFG_SETTLE:   settle_reg   <= cfg_data[9:0];
                acs_pkg::CFG_GAIN:     gain_reg     <= cfg_data;
                default:               ;
            endcase
        end
    end

    // counters, valid flag, sweep address, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg      <= '0;
            step_reg      <= '0;
            valid_reg     <= 1'b0;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_ctrs)
            begin
                tick_reg  <= '0;
                step_reg  <= '0;
                valid_reg <= 1'b0;
            end
            else if (cmd.tick_upd)
            begin
                if (tick_hit)
                begin
                    tick_reg <= '0;
                    if (step_reg != acs_pkg::STEP_MAX)
                    begin
                        step_reg <= step_reg + 14'd1;
                    end
                end
                else
                begin
                    tick_reg <= tick_inc[15:0];
                end
            end
            else if (cmd.exec && (phase_reg == PH_DONE))
            begin
                valid_reg <= 1'b1;
            end

            if (cmd.clr_en)
            begin
                clr_addr_reg <= clr_last ? '0 : clr_addr_reg + 1'b1;
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            action_reg     <= req_action;
            pos_reg        <= req_position;
            cur_reg        <= req_current_q;
            res_motor_reg  <= req_motor_id;
            res_newpos_reg <= req_position;
            res_wr_reg     <= 1'b0;
            res_idx_reg    <= '0;
            res_val_reg    <= '0;
            res_done_reg   <= 1'b0;
            res_disarm_reg <= (req_action == acs_pkg::ACT_END);
        end

        if (cmd.tick_upd)
        begin
            prod_reg <= prod_calc;
            idx_reg  <= idx_calc;
        end

        if (cmd.phase_latch)
        begin
            phase_reg  <= phase_calc;
            scaled_reg <= scaled_calc;
        end

        if (cmd.exec)
        begin
            case (phase_reg)
                PH_SET_CW:
                begin
                    res_newpos_reg <= pos_reg + PosDelta;
                end
                PH_REC_CW:
                begin
                    res_newpos_reg <= pos_reg + PosDelta;
                    res_wr_reg     <= 1'b1;
                    res_idx_reg    <= idx_reg;
                    res_val_reg    <= scaled_reg;
                end
                PH_SET_CCW:
                begin
                    res_newpos_reg <= pos_reg - PosDelta;
                end
                PH_AVG_CCW:
                begin
                    res_newpos_reg <= pos_reg - PosDelta;
                    res_wr_reg     <= 1'b1;
                    res_idx_reg    <= idx_reg;
                    res_val_reg    <= avg_val;
                end
                default:
                begin
                    res_done_reg <= 1'b1;
                end
            endcase
        end

        if (cmd.out_load)
        begin
            out_motor_reg  <= res_motor_reg;
            out_newpos_reg <= res_newpos_reg;
            out_wr_reg     <= res_wr_reg;
            out_idx_reg    <= res_idx_reg;
            out_val_reg    <= res_val_reg;
            out_done_reg   <= res_done_reg;
            out_disarm_reg <= res_disarm_reg;
        end
    end

    // table memory: one write port shared by sweep and update, one registered read
    assign mem_we    = cmd.clr_en ||
                       (cmd.exec && ((phase_reg == PH_REC_CW) || (phase_reg == PH_AVG_CCW)));
    assign mem_addr  = cmd.clr_en ? clr_addr_reg : idx_reg;
    assign mem_wdata = cmd.clr_en ? 16'sd0 :
                       ((phase_reg == PH_AVG_CCW) ? avg_val : scaled_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cog_mem[mem_addr] <= mem_wdata;
        end
        if (cmd.phase_latch)
        begin
            rdata_reg <= cog_mem[idx_reg];
        end
    end

    assign rsp_valid        = out_valid_reg;
    assign rsp_motor_out    = out_motor_reg;
    assign rsp_new_position = out_newpos_reg;
    assign rsp_table_write  = out_wr_reg;
    assign rsp_table_index  = 12'(out_idx_reg);
    assign rsp_table_value  = out_val_reg;
    assign rsp_done_res     = out_done_reg;
    assign rsp_disarm       = out_disarm_reg;

endmodule

// ===== hw/rtl/anticogging_calibration_sequencer_core.sv =====
// top level of the anticogging calibration sequencer
//
// channels: req carries one request (action, motor_id, position, current_q),
// rsp returns exactly one result per request, cfg writes the registers
// prescale_ticks (0), settle_steps (1) and current_gain (2); cfg is always ready
// and must be written only while the block is idle; the block does not enforce it.
// one request is in work at a time. a tick that completes a calibration step
// passes through decode, prescale and multiply, phase and table read, table
// write and result hand-off; a tick without a step passes through decode,
// prescale and multiply and result hand-off; an end action on a finished table
// or an unused code 3 passes through decode, result hand-off and idle.
// start, and end on an unfinished table, sweep the table one entry per cycle;
// the single table write port sets the sweep length.
// the result is loaded into an output register once that register is free and
// is held there on rsp; a new request is taken while it waits, but its own result
// stays in the datapath until rsp.ready frees the register.
// reset: registers return to their defaults, counters clear, and the table is
// cleared by a sweep of all MAP_ENTRIES entries during which req.ready stays low.
module anticogging_calibration_sequencer_core #(
    parameter int MAP_ENTRIES = 1024
) (
    input  logic          clk,
    input  logic          rst_n,
    acs_req_if.sink       req,
    acs_rsp_if.source     rsp,
    acs_cfg_if.sink       cfg
);

    acs_pkg::acs_cmd_t cmd;
    acs_pkg::acs_sts_t sts;
    logic              req_ready;

    // configuration never stalls
    assign cfg.ready = 1'b1;
    assign req.ready = req_ready;

    acs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    acs_dp #(
        .MAP_ENTRIES (MAP_ENTRIES)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .cfg_we           (cfg.valid),
        .cfg_index        (cfg.index),
        .cfg_data         (cfg.data),
        .req_action       (req.action),
        .req_motor_id     (req.motor_id),
        .req_position     (req.position),
        .req_current_q    (req.current_q),
        .rsp_ready        (rsp.ready),
        .rsp_valid        (rsp.valid),
        .rsp_motor_out    (rsp.motor_out),
        .rsp_new_position (rsp.new_position),
        .rsp_table_write  (rsp.table_write),
        .rsp_table_index  (rsp.table_index),
        .rsp_table_value  (rsp.table_value),
        .rsp_done_res     (rsp.done_res),
        .rsp_disarm       (rsp.disarm)
    );

    // no request is taken while the table sweep runs
    ap_no_req_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr_en |-> !req.ready)
        else $error("request accepted during table sweep");

    // a captured request blocks the next one
    ap_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_in |=> !req.ready)
        else $error("second request taken while one is in work");

    // a table write never comes with done or disarm
    ap_write_excl: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.table_write && (rsp.done_res || rsp.disarm)))
        else $error("table write flagged together with done or disarm");

    // the controller issues at most one datapath step per cycle
    ap_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.clr_en, cmd.load_in, cmd.tick_upd, cmd.phase_latch,
                  cmd.exec, cmd.out_load}))
        else $error("overlapping datapath commands");

endmodule
